[hw/rtl/acir_pkg.sv]
// Shared types, constants and frame builder for the IR frame pulse encoder.
`timescale 1ns / 1ps

package acir_pkg;

  localparam int FRAME_BYTES = 21;
  localparam int FRAME_BITS  = FRAME_BYTES * 8;
  localparam int BIT_IDX_W   = $clog2(FRAME_BITS);
  localparam int BYTE_POS_W  = BIT_IDX_W - 3;
  localparam int DUR_W       = 16;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 24;

  localparam logic [BYTE_POS_W-1:0] SEC1_END = BYTE_POS_W'(6);
  localparam logic [BYTE_POS_W-1:0] SEC2_END = BYTE_POS_W'(14);
  localparam logic [BYTE_POS_W-1:0] FRAME_END = BYTE_POS_W'(FRAME_BYTES);

  localparam logic [7:0] HDR_BYTE0 = 8'h83;
  localparam logic [7:0] HDR_BYTE1 = 8'h06;
  localparam logic [7:0] SEC2_BYTE = 8'h80;
  localparam logic [7:0] CMD_BYTE  = 8'h06;
  localparam logic [7:0] TEMP_MIN  = 8'd18;
  localparam logic [7:0] TEMP_MAX  = 8'd32;
  localparam logic [7:0] TEMP_AUTO = 8'd23;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_HEADER_MARK  = 3'd0,
    CFG_HEADER_SPACE = 3'd1,
    CFG_BIT_MARK     = 3'd2,
    CFG_ONE_SPACE    = 3'd3,
    CFG_ZERO_SPACE   = 3'd4,
    CFG_SECTION_GAP  = 3'd5,
    CFG_END_GAP      = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    MODE_AUTO = 3'd0,
    MODE_COOL = 3'd1,
    MODE_DRY  = 3'd2,
    MODE_FAN  = 3'd3,
    MODE_HEAT = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_HEADER = 3'b001,
    ST_BITS   = 3'b010,
    ST_FOOTER = 3'b100
  } stage_t;

  typedef struct packed {
    logic [DUR_W-1:0] header_mark_us;
    logic [DUR_W-1:0] header_space_us;
    logic [DUR_W-1:0] bit_mark_us;
    logic [DUR_W-1:0] one_space_us;
    logic [DUR_W-1:0] zero_space_us;
    logic [DUR_W-1:0] section_gap_us;
    logic [DUR_W-1:0] end_gap_us;
  } cfg_t;

  typedef struct packed {
    logic       power_on;
    logic [2:0] ac_mode;
    logic [1:0] fan_speed;
    logic [7:0] temp_celsius;
    logic       swing_on;
  } settings_t;

  typedef struct packed {
    logic [DUR_W-1:0] duration_us;
    logic             is_mark;
    logic             last;
    logic             valid_res;
  } res_t;

  function automatic logic [FRAME_BITS-1:0] build_frame(settings_t s);
    logic [FRAME_BITS-1:0] f;
    logic [2:0] mc;
    logic [1:0] fc;
    logic [7:0] t;
    logic [7:0] toff;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [7:0] b8;
    logic       is_auto;
    is_auto = 1'b0;
    unique case (s.ac_mode)
      MODE_COOL: mc = 3'd2;
      MODE_DRY:  mc = 3'd3;
      MODE_FAN:  mc = 3'd4;
      MODE_HEAT: mc = 3'd0;
      default: begin
        mc = 3'd1;
        is_auto = 1'b1;
      end
    endcase
    unique case (s.fan_speed)
      2'd0: fc = 2'd0;
      2'd1: fc = 2'd3;
      2'd2: fc = 2'd2;
      default: fc = 2'd1;
    endcase
    t = s.temp_celsius;
    if (t < TEMP_MIN) t = TEMP_MIN;
    if (t > TEMP_MAX) t = TEMP_MAX;
    if (is_auto) t = TEMP_AUTO;
    toff = t - TEMP_MIN;
    b2 = {s.swing_on, 4'b0000, s.power_on, fc};
    b3 = {toff[3:0], 1'b0, mc};
    b8 = {1'b0, s.swing_on, 6'b000000};
    f = '0;
    f[0*8 +: 8]  = HDR_BYTE0;
    f[1*8 +: 8]  = HDR_BYTE1;
    f[2*8 +: 8]  = b2;
    f[3*8 +: 8]  = b3;
    f[6*8 +: 8]  = SEC2_BYTE;
    f[8*8 +: 8]  = b8;
    f[13*8 +: 8] = b2 ^ b3 ^ SEC2_BYTE ^ b8;
    f[15*8 +: 8] = CMD_BYTE;
    f[20*8 +: 8] = CMD_BYTE;
    return f;
  endfunction

endpackage

[hw/rtl/acir_seq.sv]
// Frame store and pulse sequencer: one duration per fetch item.
`timescale 1ns / 1ps

module acir_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic               op,
  input  acir_pkg::settings_t settings,
  input  acir_pkg::cfg_t     cfg,
  output acir_pkg::res_t     res,
  output logic               res_vld
);
  import acir_pkg::*;

  logic [FRAME_BITS-1:0] frame_r;
  logic [FRAME_BITS-1:0] frame_nxt;
  logic                  load;
  logic [BYTE_POS_W-1:0] byte_pos_r, byte_pos_nxt;
  logic [2:0]            bit_pos_r, bit_pos_nxt;
  logic                  mark_r, mark_nxt;
  stage_t                stage_r, stage_nxt;
  logic                  active_r, active_nxt;
  logic [BIT_IDX_W-1:0]  bit_idx;
  logic                  cur_bit;

  assign bit_idx = {byte_pos_r, bit_pos_r};
  assign cur_bit = (byte_pos_r < FRAME_END) ? frame_r[bit_idx] : 1'b0;
  assign load      = step && (op == OP_LOAD);
  assign frame_nxt = build_frame(settings);
  assign res_vld   = step && (op == OP_FETCH);

  always_comb begin
    byte_pos_nxt = byte_pos_r;
    bit_pos_nxt  = bit_pos_r;
    mark_nxt     = mark_r;
    stage_nxt    = stage_r;
    active_nxt   = active_r;
    res          = '0;
    if (load) begin
      byte_pos_nxt = '0;
      bit_pos_nxt  = '0;
      mark_nxt     = 1'b1;
      stage_nxt    = ST_HEADER;
      active_nxt   = 1'b1;
    end else if (res_vld && active_r) begin
      res.valid_res = 1'b1;
      if (stage_r == ST_HEADER) begin
        if (mark_r) begin
          res.duration_us = cfg.header_mark_us;
          res.is_mark     = 1'b1;
          mark_nxt        = 1'b0;
        end else begin
          res.duration_us = cfg.header_space_us;
          mark_nxt        = 1'b1;
          stage_nxt       = ST_BITS;
        end
      end else if (stage_r == ST_BITS) begin
        if (mark_r) begin
          res.duration_us = cfg.bit_mark_us;
          res.is_mark     = 1'b1;
          mark_nxt        = 1'b0;
        end else begin
          res.duration_us = cur_bit ? cfg.one_space_us : cfg.zero_space_us;
          mark_nxt        = 1'b1;
          bit_pos_nxt     = bit_pos_r + 3'd1;
          if (bit_pos_r == 3'd7) begin
            byte_pos_nxt = byte_pos_r + BYTE_POS_W'(1);
            if (byte_pos_nxt == SEC1_END || byte_pos_nxt == SEC2_END ||
                byte_pos_nxt >= FRAME_END) begin
              stage_nxt = ST_FOOTER;
            end
          end
        end
      end else begin
        if (mark_r) begin
          res.duration_us = cfg.bit_mark_us;
          res.is_mark     = 1'b1;
          mark_nxt        = 1'b0;
        end else if (byte_pos_r >= FRAME_END) begin
          res.duration_us = cfg.end_gap_us;
          res.last        = 1'b1;
          byte_pos_nxt    = '0;
          bit_pos_nxt     = '0;
          mark_nxt        = 1'b1;
          stage_nxt       = ST_HEADER;
          active_nxt      = 1'b0;
        end else begin
          res.duration_us = cfg.section_gap_us;
          mark_nxt        = 1'b1;
          stage_nxt       = ST_BITS;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= frame_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_pos_r <= '0;
      bit_pos_r  <= '0;
      mark_r     <= 1'b1;
      stage_r    <= ST_HEADER;
      active_r   <= 1'b0;
    end else begin
      byte_pos_r <= byte_pos_nxt;
      bit_pos_r  <= bit_pos_nxt;
      mark_r     <= mark_nxt;
      stage_r    <= stage_nxt;
      active_r   <= active_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_at_header: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (stage_r == ST_HEADER && mark_r && byte_pos_r == '0))
    else $error("inactive sequencer not parked at header");

  a_byte_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_pos_r <= FRAME_END)
    else $error("byte position beyond frame end");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.last) |=> !active_r)
    else $error("frame still active after end gap");
`endif

endmodule

[hw/rtl/ac_ir_frame_pulse_encoder.sv]
// Top level: config registers, sequencer and output skid stage.
`timescale 1ns / 1ps
// A fetch item's duration reaches out_* through the output register or skid.
// Throughput: one item per cycle while the skid is empty; a load gives no output.
// The output register plus a one-entry skid absorb one item while out stalls.
// Reset (rst_n low, synchronous): timing registers return to defaults,
// no frame active, output and skid empty; the frame store is not cleared.

module ac_ir_frame_pulse_encoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // power_on, ac_mode[2:0], fan_speed[1:0], temp_celsius[7:0], swing_on, pad
  input  logic [acir_pkg::IN_DATA_W-1:0]      in_tdata,
  // op
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // duration_us[15:0], is_mark, pad
  output logic [acir_pkg::OUT_DATA_W-1:0]     out_tdata,
  // valid_res
  output logic                                out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_we,
  input  logic [acir_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [acir_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import acir_pkg::*;

  cfg_t      cfg_r;
  settings_t settings;
  res_t      res;
  logic      res_vld;
  logic      in_fire;
  logic      out_fire;
  res_t      out_r;
  logic      out_vld_r;
  res_t      skid_r;
  logic      skid_vld_r;

  assign in_tready = !skid_vld_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_vld_r && out_tready;

  assign settings.power_on     = in_tdata[0];
  assign settings.ac_mode      = in_tdata[3:1];
  assign settings.fan_speed    = in_tdata[5:4];
  assign settings.temp_celsius = in_tdata[13:6];
  assign settings.swing_on     = in_tdata[14];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_mark_us  <= 16'd8950;
      cfg_r.header_space_us <= 16'd4484;
      cfg_r.bit_mark_us     <= 16'd597;
      cfg_r.one_space_us    <= 16'd1649;
      cfg_r.zero_space_us   <= 16'd533;
      cfg_r.section_gap_us  <= 16'd7920;
      cfg_r.end_gap_us      <= 16'd30000;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_HEADER_MARK:  cfg_r.header_mark_us  <= cfg_wdata;
        CFG_HEADER_SPACE: cfg_r.header_space_us <= cfg_wdata;
        CFG_BIT_MARK:     cfg_r.bit_mark_us     <= cfg_wdata;
        CFG_ONE_SPACE:    cfg_r.one_space_us    <= cfg_wdata;
        CFG_ZERO_SPACE:   cfg_r.zero_space_us   <= cfg_wdata;
        CFG_SECTION_GAP:  cfg_r.section_gap_us  <= cfg_wdata;
        CFG_END_GAP:      cfg_r.end_gap_us      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  acir_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (in_fire),
    .op       (in_tuser),
    .settings (settings),
    .cfg      (cfg_r),
    .res      (res),
    .res_vld  (res_vld)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_fire) begin
        skid_vld_r <= 1'b0;
      end
    end else if (res_vld) begin
      if (out_vld_r && !out_tready) begin
        skid_vld_r <= 1'b1;
      end else begin
        out_vld_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (res_vld) begin
      if (out_vld_r && !out_tready) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W - DUR_W - 1){1'b0}}, out_r.is_mark, out_r.duration_us};
  assign out_tuser  = out_r.valid_res;
  assign out_tlast  = out_r.last;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds an item while output is empty");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && out_vld_r && !out_tready) |=> skid_vld_r)
    else $error("stalled item not captured in skid");

  a_last_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.last) |-> out_r.valid_res)
    else $error("last flag on an invalid result");
`endif

endmodule
